/* rtl/mtp3_message_discriminator_top_macros.svh */
// assertion macros for the mtp3 message discriminator
`ifndef MTP3_MESSAGE_DISCRIMINATOR_TOP_MACROS_SVH
`define MTP3_MESSAGE_DISCRIMINATOR_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define MD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/md_pkg.sv */
// package: constants, types and helpers of the mtp3 message discriminator
`default_nettype none
package md_pkg;
    localparam int MAX_PATTERN_DEF = 15;
    localparam logic [3:0] SI_NET_MNG = 4'd0;
    localparam logic [3:0] SI_STD_TEST = 4'd1;
    localparam logic [3:0] SI_ISUP = 4'd5;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_ISUP = 2'd2;

    localparam logic [3:0] V_WRONG_NI = 4'd0;
    localparam logic [3:0] V_WRONG_DPC = 4'd1;
    localparam logic [3:0] V_SLTA_SENT = 4'd2;
    localparam logic [3:0] V_LINK_UP = 4'd3;
    localparam logic [3:0] V_SLTM_SENT = 4'd4;
    localparam logic [3:0] V_ISUP_DONE = 4'd5;
    localparam logic [3:0] V_IGNORED = 4'd6;
    localparam logic [3:0] V_TEST_FAIL = 4'd7;
    localparam logic [3:0] V_MGMT_UNH = 4'd8;

    localparam logic [1:0] REG_VARIANT = 2'd0;
    localparam logic [1:0] REG_OWN_PC = 2'd1;
    localparam logic [1:0] REG_NI = 2'd2;
    localparam logic [1:0] REG_LINK_COUNT = 2'd3;

    localparam logic [7:0] H_SLTA = 8'h21;
    localparam logic [7:0] H_SLTM = 8'h11;
    localparam int FIXED_LEN = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_STORE,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] verdict;
        logic [7:0] out_byte;
        logic [3:0] link_index;
        logic       last_out;
    } result_t;

    function automatic logic [7:0] fixed_byte(input logic [3:0] i);
        logic [7:0] r;
        begin
            case (i)
                4'd0: r = 8'h32;
                4'd1: r = 8'h35;
                4'd2: r = 8'h36;
                4'd3: r = 8'h34;
                4'd4: r = 8'h32;
                4'd5: r = 8'h38;
                4'd6: r = 8'h36;
                4'd7: r = 8'h32;
                4'd8: r = 8'h38;
                default: r = 8'h38;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/md_ram.sv */
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module md_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/mtp3_message_discriminator_top.sv */
// top level of the mtp3 message discriminator
`default_nettype none
// Takes one SS7 MSU byte per request, SIO first. The SIO, routing label,
// heading and length byte are kept in flops, and the test pattern is filed in
// a 32-entry message memory where entry i holds pattern byte i. Each ordinary
// byte passes through accept, file and decide before the next request is
// taken. A byte that is forwarded as ISUP payload takes an extra decide step,
// plus any time the output spends stalled while that byte waits to leave.
// On the final byte, the verdict and then the reply burst leave one result per
// cycle while the output is not stalled (up to 26 results). A clearing pass
// then zeroes all 32 entries of the message memory, and no request is taken
// during that pass. The same clearing pass runs after reset, before the first
// request. Results leave through a single result register. A result waiting
// there holds up the next result and the byte that produces it.
module mtp3_message_discriminator_top #(
    parameter int MAX_PATTERN = md_pkg::MAX_PATTERN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        last,
    input  wire logic [3:0]  link_code,
    input  wire logic [23:0] link_peer_point_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [3:0]       verdict,
    output logic [7:0]       out_byte,
    output logic [3:0]       link_index,
    output logic             last_out
);
    import md_pkg::*;
    `include "mtp3_message_discriminator_top_macros.svh"

    localparam int MEM_DEPTH = 32;
    localparam int AW = 5;

    // configuration
    logic        variant_reg;
    logic [23:0] own_pc_reg;
    logic [1:0]  ni_reg;
    logic [4:0]  link_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg    <= 1'b0;
            own_pc_reg     <= '0;
            ni_reg         <= '0;
            link_count_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VARIANT:    variant_reg    <= cfg_data[0];
                REG_OWN_PC:     own_pc_reg     <= cfg_data;
                REG_NI:         ni_reg         <= cfg_data[1:0];
                REG_LINK_COUNT: link_count_reg <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // message memory: pattern bytes, entry i is pattern byte i
    // a pattern byte's entry follows the variant in force when it arrives
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    md_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_msg_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // header fields are shadowed in flops, the pattern lives only in memory
    // (label shadow keeps dpc/opc decode cheap at the end)
    state_t      state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  sio_reg, sio_next;
    logic [7:0]  lab_reg [7];
    logic [7:0]  head_reg, head_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [3:0]  slc_reg;
    logic [23:0] peer_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic [4:0]  total_reg, total_next;
    logic [3:0]  link_reg, link_next;
    logic        lab_we;
    logic [2:0]  lab_idx;
    result_t     res_reg, res_next;
    logic        ovalid_reg, ovalid_next;
    logic        isup_pending_reg, isup_pending_next;

    // label decode
    logic [4:0]  rl;
    logic [23:0] dpc, opc, own_pc, peer_pc;
    logic        ni_ok, dpc_ok;
    logic [3:0]  si, h0, h1;
    logic [3:0]  psize;
    logic [4:0]  lc;
    logic [8:0]  mod_rem;
    logic [3:0]  link_mod;

    always_comb
    begin
        rl = variant_reg ? 5'd7 : 5'd4;
        if (variant_reg)
        begin
            dpc = {lab_reg[2], lab_reg[1], lab_reg[0]};
            opc = {lab_reg[5], lab_reg[4], lab_reg[3]};
            own_pc = own_pc_reg;
            peer_pc = link_peer_point_code;
        end
        else
        begin
            dpc = {10'd0, lab_reg[1][5:0], lab_reg[0]};
            opc = {10'd0, lab_reg[3][3:0], lab_reg[2], lab_reg[1][7:6]};
            own_pc = {10'd0, own_pc_reg[13:0]};
            peer_pc = {10'd0, link_peer_point_code[13:0]};
        end
        peer_pc = variant_reg ? peer_reg : {10'd0, peer_reg[13:0]};
        ni_ok = (sio_reg[7:6] == ni_reg);
        dpc_ok = (dpc == own_pc);
        si = sio_reg[3:0];
        h0 = head_reg[3:0];
        h1 = head_reg[7:4];
        psize = (plen_reg[7:4] > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : plen_reg[7:4];
        lc = (link_count_reg == 5'd0) ? 5'd1 : link_count_reg;
        // slc modulo lc by restoring division, one compare and subtract per quotient bit
        mod_rem = {5'd0, slc_reg};
        if (mod_rem >= {1'b0, lc, 3'd0}) mod_rem = mod_rem - {1'b0, lc, 3'd0};
        if (mod_rem >= {2'b0, lc, 2'd0}) mod_rem = mod_rem - {2'b0, lc, 2'd0};
        if (mod_rem >= {3'b0, lc, 1'b0}) mod_rem = mod_rem - {3'b0, lc, 1'b0};
        if (mod_rem >= {4'b0, lc}) mod_rem = mod_rem - {4'b0, lc};
        link_mod = mod_rem[3:0];
    end

    // reply sequence: index into the burst built from header flops and memory
    logic       sltm_reply;
    logic [23:0] r_dpc;
    logic [7:0]  reply_byte;
    logic [4:0]  body;
    always_comb
    begin
        sltm_reply = (si == SI_NET_MNG);
        r_dpc = sltm_reply ? peer_pc : opc;
        reply_byte = 8'd0;
        body = cnt_reg - 5'd1;
        if (cnt_reg == 5'd1)
        begin
            reply_byte = {ni_reg, 2'b00, SI_STD_TEST};
        end
        else if (body <= rl)
        begin
            if (variant_reg)
            begin
                case (body)
                    5'd1: reply_byte = r_dpc[7:0];
                    5'd2: reply_byte = r_dpc[15:8];
                    5'd3: reply_byte = r_dpc[23:16];
                    5'd4: reply_byte = own_pc[7:0];
                    5'd5: reply_byte = own_pc[15:8];
                    5'd6: reply_byte = own_pc[23:16];
                    default: reply_byte = {4'd0, slc_reg};
                endcase
            end
            else
            begin
                case (body)
                    5'd1: reply_byte = r_dpc[7:0];
                    5'd2: reply_byte = {own_pc[1:0], r_dpc[13:8]};
                    5'd3: reply_byte = own_pc[9:2];
                    default: reply_byte = {slc_reg, own_pc[13:10]};
                endcase
            end
        end
        else if (body == rl + 5'd1)
        begin
            reply_byte = sltm_reply ? H_SLTM : H_SLTA;
        end
        else if (body == rl + 5'd2)
        begin
            reply_byte = sltm_reply ? 8'hA0 : {psize, 4'd0};
        end
        else
        begin
            reply_byte = sltm_reply ? fixed_byte(4'(body - rl - 5'd3)) : ram_rdata;
        end
    end

    logic       out_free;

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        sio_next = sio_reg;
        head_next = head_reg;
        plen_next = plen_reg;
        cnt_next = cnt_reg;
        total_next = total_reg;
        link_next = link_reg;
        res_next = res_reg;
        ovalid_next = ovalid_reg;
        isup_pending_next = isup_pending_reg;
        ram_we = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = byte_reg;
        ram_raddr = pos_reg;
        lab_we = 1'b0;
        lab_idx = 3'(pos_reg - 5'd1);
        in_stall = 1'b1;
        out_free = !ovalid_reg || !out_stall;
        if (ovalid_reg && !out_stall) ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid) state_next = ST_READ;
            end
            ST_READ:
            begin
                // file the byte at its position
                state_next = ST_STORE;
                if (pos_reg == 5'd0)
                begin
                    sio_next = byte_reg;
                end
                else if (pos_reg <= rl)
                begin
                    lab_we = 1'b1;
                end
                else if (pos_reg == rl + 5'd1)
                begin
                    head_next = byte_reg;
                end
                else if (pos_reg == rl + 5'd2)
                begin
                    plen_next = byte_reg;
                end
                else if (pos_reg - rl - 5'd3 < 5'(MAX_PATTERN))
                begin
                    ram_we = 1'b1;
                    ram_waddr = pos_reg - rl - 5'd3;
                end
            end
            ST_STORE:
            begin
                // isup forward, then verdict prep
                if (!isup_pending_reg && pos_reg > rl && si == SI_ISUP && ni_ok && dpc_ok)
                begin
                    isup_pending_next = 1'b1;
                end
                if (isup_pending_reg || (pos_reg > rl && si == SI_ISUP && ni_ok && dpc_ok
                    && !isup_pending_reg))
                begin
                    if (out_free && isup_pending_reg)
                    begin
                        res_next = '{KIND_ISUP, 4'd0, byte_reg, 4'd0, !last_reg};
                        res_next.last_out = !last_reg;
                        ovalid_next = 1'b1;
                        isup_pending_next = 1'b0;
                        if (!last_reg)
                        begin
                            if (pos_reg != 5'd31) pos_next = pos_reg + 5'd1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cnt_next = 5'd0;
                            state_next = ST_EMIT;
                        end
                    end
                end
                else if (!last_reg)
                begin
                    if (pos_reg != 5'd31) pos_next = pos_reg + 5'd1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = 5'd0;
                    state_next = ST_EMIT;
                end
                link_next = link_mod;
                ram_raddr = 5'd0;
            end
            ST_EMIT:
            begin
                // cnt 0 verdict, then reply bytes; memory read one ahead
                ram_raddr = 5'(cnt_reg - rl - 5'd3);
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (cnt_reg == 5'd0)
                    begin
                        res_next = '{KIND_VERDICT, V_IGNORED, 8'd0, 4'd0, 1'b1};
                        total_next = 5'd0;
                        if (!ni_ok) res_next.verdict = V_WRONG_NI;
                        else if (!dpc_ok) res_next.verdict = V_WRONG_DPC;
                        else if (si == SI_STD_TEST)
                        begin
                            if (h0 == 4'd1 && h1 == 4'd1)
                            begin
                                res_next.verdict = V_SLTA_SENT;
                                total_next = rl + 5'd3 + 5'(psize);
                            end
                            else if (h0 == 4'd1 && h1 == 4'd2) res_next.verdict = V_LINK_UP;
                            else res_next.verdict = V_TEST_FAIL;
                        end
                        else if (si == SI_ISUP) res_next.verdict = V_ISUP_DONE;
                        else if (si == SI_NET_MNG)
                        begin
                            if (h0 == 4'd7 && h1 == 4'd1)
                            begin
                                res_next.verdict = V_SLTM_SENT;
                                total_next = rl + 5'd3 + 5'(FIXED_LEN);
                            end
                            else res_next.verdict = V_MGMT_UNH;
                        end
                        res_next.last_out = (total_next == 5'd0);
                        if (total_next == 5'd0) state_next = ST_CLEAR;
                        cnt_next = 5'd1;
                        ram_raddr = 5'd0;
                    end
                    else
                    begin
                        res_next = '{KIND_REPLY, 4'd0, reply_byte, link_reg,
                                     cnt_reg == total_reg};
                        cnt_next = cnt_reg + 5'd1;
                        if (cnt_reg == total_reg) state_next = ST_CLEAR;
                    end
                end
                else
                begin
                    ram_raddr = 5'(cnt_reg - rl - 5'd4);
                end
            end
            ST_CLEAR:
            begin
                // zero the message memory, one entry a cycle
                ram_we = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = 8'd0;
                cnt_next = cnt_reg + 5'd1;
                sio_next = 8'd0;
                head_next = 8'd0;
                plen_next = 8'd0;
                pos_next = 5'd0;
                if (cnt_reg == 5'd31) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_EMIT && state_next == ST_CLEAR) cnt_next = 5'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            pos_reg          <= '0;
            sio_reg          <= '0;
            head_reg         <= '0;
            plen_reg         <= '0;
            cnt_reg          <= '0;
            total_reg        <= '0;
            link_reg         <= '0;
            ovalid_reg       <= 1'b0;
            isup_pending_reg <= 1'b0;
            for (int i = 0; i < 7; i++) lab_reg[i] <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            sio_reg          <= sio_next;
            head_reg         <= head_next;
            plen_reg         <= plen_next;
            cnt_reg          <= cnt_next;
            total_reg        <= total_next;
            link_reg         <= link_next;
            ovalid_reg       <= ovalid_next;
            isup_pending_reg <= isup_pending_next;
            if (lab_we) lab_reg[lab_idx] <= byte_reg;
            if (state_reg == ST_CLEAR)
            begin
                for (int i = 0; i < 7; i++) lab_reg[i] <= '0;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            byte_reg <= msg_byte;
            last_reg <= last;
            slc_reg  <= link_code;
            peer_reg <= link_peer_point_code;
        end
        res_reg <= res_next;
    end

    assign out_valid  = ovalid_reg;
    assign kind       = res_reg.kind;
    assign verdict    = res_reg.verdict;
    assign out_byte   = res_reg.out_byte;
    assign link_index = res_reg.link_index;
    assign last_out   = res_reg.last_out;

    `MD_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, in_stall, "request taken while busy")
    `MD_ASSERT_NXT(a_hold_result, out_valid && out_stall, out_valid && $stable(res_reg),
        "stalled result changed")
    `MD_ASSERT_IMP(a_clear_no_out, state_reg == ST_CLEAR && !out_valid, !ram_we || ram_wdata == 8'd0,
        "clearing pass wrote data")
endmodule
`default_nettype wire

/* tb/mtp3_message_discriminator_top_tb.sv */
// testbench for the mtp3 message discriminator top level
`default_nettype none
module mtp3_message_discriminator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import md_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    // clearing pass plus reply burst plus margin
    localparam int SETTLE_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  msg_byte;
    logic        last;
    logic [3:0]  link_code;
    logic [23:0] link_peer_point_code;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [3:0]  verdict;
    logic [7:0]  out_byte;
    logic [3:0]  link_index;
    logic        last_out;

    mtp3_message_discriminator_top u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .msg_byte             (msg_byte),
        .last                 (last),
        .link_code            (link_code),
        .link_peer_point_code (link_peer_point_code),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .kind                 (kind),
        .verdict              (verdict),
        .out_byte             (out_byte),
        .link_index           (link_index),
        .last_out             (last_out)
    );

    // shadow of the configuration registers
    logic        sh_variant;
    logic [23:0] sh_own_pc;
    logic [1:0]  sh_ni;
    logic [4:0]  sh_link_count;

    // shadow of the message being received
    logic [4:0]  rx_pos;
    logic [7:0]  rx_sio;
    logic [7:0]  rx_label [7];
    logic [7:0]  rx_heading;
    logic [7:0]  rx_len_byte;
    logic [7:0]  rx_pattern [15];

    result_t     expected_results [$];
    result_t     burst [$];
    logic [7:0]  msu [$];

    int          cycles;
    int          mismatches;
    bit          calm;
    int          stall_hold;

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // mismatch reporting, prints are capped but every mismatch counts
    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    task automatic clear_message();
        rx_pos = '0;
        rx_sio = '0;
        rx_heading = '0;
        rx_len_byte = '0;
        foreach (rx_label[i]) rx_label[i] = '0;
        foreach (rx_pattern[i]) rx_pattern[i] = '0;
    endtask

    function automatic logic [23:0] label_dpc();
        if (sh_variant)
            return {rx_label[2], rx_label[1], rx_label[0]};
        return {10'd0, rx_label[1][5:0], rx_label[0]};
    endfunction

    function automatic logic [23:0] label_opc();
        if (sh_variant)
            return {rx_label[5], rx_label[4], rx_label[3]};
        return {10'd0, rx_label[3][3:0], rx_label[2], rx_label[1][7:6]};
    endfunction

    function automatic logic [23:0] own_pc();
        return sh_variant ? sh_own_pc : {10'd0, sh_own_pc[13:0]};
    endfunction

    task automatic add(input logic [1:0] k, input logic [3:0] v, input logic [7:0] b,
                       input logic [3:0] l);
        result_t r;
        r.kind = k;
        r.verdict = v;
        r.out_byte = b;
        r.link_index = l;
        r.last_out = 1'b0;
        burst.push_back(r);
    endtask

    task automatic add_label(input logic [23:0] dpc, input logic [23:0] opc,
                             input logic [3:0] sls, input logic [3:0] l);
        if (sh_variant)
        begin
            add(KIND_REPLY, '0, dpc[7:0], l);
            add(KIND_REPLY, '0, dpc[15:8], l);
            add(KIND_REPLY, '0, dpc[23:16], l);
            add(KIND_REPLY, '0, opc[7:0], l);
            add(KIND_REPLY, '0, opc[15:8], l);
            add(KIND_REPLY, '0, opc[23:16], l);
            add(KIND_REPLY, '0, {4'd0, sls}, l);
        end
        else
        begin
            add(KIND_REPLY, '0, dpc[7:0], l);
            add(KIND_REPLY, '0, {opc[1:0], dpc[13:8]}, l);
            add(KIND_REPLY, '0, opc[9:2], l);
            add(KIND_REPLY, '0, {sls, opc[13:10]}, l);
        end
    endtask

    // works out what one accepted msu byte produces
    task automatic predict_msu_byte(input logic [7:0] b, input logic lst,
                                    input logic [3:0] slc, input logic [23:0] peer);
        int          rl;
        int          p;
        logic        hdr_ok;
        logic [3:0]  si;
        logic [3:0]  lnk;
        logic [7:0]  sio_tx;
        logic [3:0]  size;
        int          lc;
        result_t     r;
        rl = sh_variant ? 7 : 4;
        p = rx_pos;
        burst.delete();
        if (p == 0) rx_sio = b;
        else if (p <= rl) rx_label[(p - 1) % 7] = b;
        else if (p == rl + 1) rx_heading = b;
        else if (p == rl + 2) rx_len_byte = b;
        else if (p - rl - 3 < 15) rx_pattern[p - rl - 3] = b;

        hdr_ok = (rx_sio[7:6] == sh_ni) && (label_dpc() == own_pc());
        if (p > rl && rx_sio[3:0] == SI_ISUP && hdr_ok)
            add(KIND_ISUP, '0, b, '0);
        if (rx_pos < 5'd31) rx_pos++;

        if (lst)
        begin
            si = rx_sio[3:0];
            lc = (sh_link_count == 0) ? 1 : sh_link_count;
            lnk = 4'(int'(slc) % lc);
            sio_tx = {sh_ni, 2'b00, SI_STD_TEST};
            if (rx_sio[7:6] != sh_ni)
                add(KIND_VERDICT, V_WRONG_NI, '0, '0);
            else if (label_dpc() != own_pc())
                add(KIND_VERDICT, V_WRONG_DPC, '0, '0);
            else if (si == SI_STD_TEST)
            begin
                if (rx_heading == 8'h11)
                begin
                    size = rx_len_byte[7:4];
                    add(KIND_VERDICT, V_SLTA_SENT, '0, '0);
                    add(KIND_REPLY, '0, sio_tx, lnk);
                    add_label(label_opc(), own_pc(), slc, lnk);
                    add(KIND_REPLY, '0, H_SLTA, lnk);
                    add(KIND_REPLY, '0, {size, 4'd0}, lnk);
                    for (int i = 0; i < size; i++)
                        add(KIND_REPLY, '0, rx_pattern[i], lnk);
                end
                else if (rx_heading == 8'h21)
                    add(KIND_VERDICT, V_LINK_UP, '0, '0);
                else
                    add(KIND_VERDICT, V_TEST_FAIL, '0, '0);
            end
            else if (si == SI_ISUP)
                add(KIND_VERDICT, V_ISUP_DONE, '0, '0);
            else if (si == SI_NET_MNG)
            begin
                if (rx_heading == 8'h17)
                begin
                    add(KIND_VERDICT, V_SLTM_SENT, '0, '0);
                    add(KIND_REPLY, '0, sio_tx, lnk);
                    add_label(sh_variant ? peer : {10'd0, peer[13:0]}, own_pc(), slc, lnk);
                    add(KIND_REPLY, '0, H_SLTM, lnk);
                    add(KIND_REPLY, '0, 8'hA0, lnk);
                    for (int i = 0; i < FIXED_LEN; i++)
                        add(KIND_REPLY, '0, fixed_byte(4'(i)), lnk);
                end
                else
                    add(KIND_VERDICT, V_MGMT_UNH, '0, '0);
            end
            else
                add(KIND_VERDICT, V_IGNORED, '0, '0);
            clear_message();
        end

        if (burst.size() > 0)
        begin
            r = burst.pop_back();
            r.last_out = 1'b1;
            burst.push_back(r);
        end
        foreach (burst[i]) expected_results.push_back(burst[i]);
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report($sformatf("unexpected result kind %0d byte %h", kind, out_byte));
            else
            begin
                e = expected_results.pop_front();
                if (kind !== e.kind)
                    report($sformatf("kind %0d, want %0d", kind, e.kind));
                if (verdict !== e.verdict)
                    report($sformatf("verdict %0d, want %0d", verdict, e.verdict));
                if (out_byte !== e.out_byte)
                    report($sformatf("out_byte %h, want %h", out_byte, e.out_byte));
                if (link_index !== e.link_index)
                    report($sformatf("link_index %0d, want %0d", link_index, e.link_index));
                if (last_out !== e.last_out)
                    report($sformatf("last_out %b, want %b", last_out, e.last_out));
            end
        end
    end

    // receiver back-pressure: mostly brief stalls, occasional long ones
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            stall_hold <= $urandom_range(5, 25);
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 9) < 3);
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one msu byte as a request; returns at the edge where it was taken, or after the random idle gap that follows it
    task automatic send_byte(input logic [7:0] b, input logic lst);
        logic [3:0]  slc;
        logic [23:0] peer;
        int          gap;
        slc = 4'($urandom_range(0, 15));
        peer = 24'($urandom_range(0, 24'hffffff));
        in_valid <= 1'b1;
        msg_byte <= b;
        last <= lst;
        link_code <= slc;
        link_peer_point_code <= peer;
        do @(posedge clk); while (in_stall);
        predict_msu_byte(b, lst, slc, peer);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_msu();
        foreach (msu[i]) send_byte(msu[i], i == msu.size() - 1);
    endtask

    // sio, routing label and heading; pattern or payload bytes added afterwards
    task automatic build_msu(input logic [3:0] si, input logic [1:0] ni,
                             input logic [23:0] dpc, input logic [23:0] opc,
                             input logic [3:0] sls, input logic [7:0] heading,
                             input logic [7:0] len_byte, input int npat);
        msu.delete();
        msu.push_back({ni, 2'($urandom_range(0, 3)), si});
        if (sh_variant)
        begin
            msu.push_back(dpc[7:0]);
            msu.push_back(dpc[15:8]);
            msu.push_back(dpc[23:16]);
            msu.push_back(opc[7:0]);
            msu.push_back(opc[15:8]);
            msu.push_back(opc[23:16]);
            msu.push_back({4'($urandom_range(0, 15)), sls});
        end
        else
        begin
            msu.push_back(dpc[7:0]);
            msu.push_back({opc[1:0], dpc[13:8]});
            msu.push_back(opc[9:2]);
            msu.push_back({sls, opc[13:10]});
        end
        msu.push_back(heading);
        msu.push_back(len_byte);
        repeat (npat) msu.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [23:0] rand_pc();
        return 24'($urandom_range(0, 24'hffffff));
    endfunction

    // wait for all results, then for the clearing pass to finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_VARIANT:    sh_variant = val[0];
            REG_OWN_PC:     sh_own_pc = val;
            REG_NI:         sh_ni = val[1:0];
            REG_LINK_COUNT: sh_link_count = val[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic v, input logic [23:0] pc, input logic [1:0] ni,
                             input logic [4:0] lc);
        wait_idle();
        write_reg(REG_VARIANT, {23'd0, v});
        write_reg(REG_OWN_PC, pc);
        write_reg(REG_NI, {22'd0, ni});
        write_reg(REG_LINK_COUNT, {19'd0, lc});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // every verdict path once, with short patterns to keep it brief
    task automatic test_verdicts();
        build_msu(SI_STD_TEST, sh_ni, own_pc(), rand_pc(), 4'hF, 8'h11, 8'h20, 2);
        send_msu();
        build_msu(SI_STD_TEST, sh_ni, own_pc(), rand_pc(), 4'h0, 8'h21, 8'h00, 0);
        send_msu();
        build_msu(SI_NET_MNG, sh_ni, own_pc(), rand_pc(), 4'h5, 8'h17, 8'h00, 0);
        send_msu();
        build_msu(SI_ISUP, sh_ni, own_pc(), rand_pc(), 4'h3, 8'hAA, 8'h55, 1);
        send_msu();
        build_msu(SI_STD_TEST, ~sh_ni, own_pc(), rand_pc(), 4'h1, 8'h11, 8'h10, 0);
        send_msu();
        build_msu(SI_STD_TEST, sh_ni, ~own_pc(), rand_pc(), 4'h1, 8'h11, 8'h10, 0);
        send_msu();
        build_msu(SI_STD_TEST, sh_ni, own_pc(), rand_pc(), 4'h2, 8'h31, 8'h00, 0);
        send_msu();
        build_msu(SI_NET_MNG, sh_ni, own_pc(), rand_pc(), 4'h2, 8'h27, 8'h00, 0);
        send_msu();
        build_msu(4'hF, sh_ni, own_pc(), rand_pc(), 4'h2, 8'h11, 8'h00, 0);
        send_msu();
    endtask

    // short message: missing bytes read as zero
    task automatic test_short_message();
        logic [23:0] pc;
        pc = own_pc();
        msu.delete();
        msu.push_back({sh_ni, 2'b00, SI_STD_TEST});
        send_msu();
        msu.delete();
        msu.push_back({sh_ni, 2'b00, SI_ISUP});
        msu.push_back(pc[7:0]);
        send_msu();
    endtask

    // long test message runs past the pattern store and the position ceiling,
    // and asks for the longest reply burst
    task automatic test_long_message();
        build_msu(SI_STD_TEST, sh_ni, own_pc(), rand_pc(), 4'h9, 8'h11, 8'hF0, 23);
        send_msu();
    endtask

    // mostly well-formed messages with random content, some broken or pure noise
    task automatic test_random_traffic(input int byte_budget);
        int sent;
        int sel;
        int n;
        logic [3:0] sz;
        sent = 0;
        while (sent < byte_budget)
        begin
            sel = $urandom_range(0, 11);
            sz = 4'($urandom_range(0, 15));
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : sz;
            case (sel)
                0, 1, 2:
                    build_msu(SI_STD_TEST, sh_ni, own_pc(), rand_pc(), 4'($urandom_range(0, 15)),
                              8'h11, {sz, 4'($urandom_range(0, 15))}, n);
                3:
                    build_msu(SI_STD_TEST, sh_ni, own_pc(), rand_pc(), 4'($urandom_range(0, 15)),
                              8'h21, 8'($urandom_range(0, 255)), $urandom_range(0, 3));
                4, 5:
                    build_msu(SI_NET_MNG, sh_ni, own_pc(), rand_pc(), 4'($urandom_range(0, 15)),
                              8'h17, 8'($urandom_range(0, 255)), $urandom_range(0, 2));
                6, 7:
                    build_msu(SI_ISUP, sh_ni, own_pc(), rand_pc(), 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 8));
                8:
                    build_msu(4'($urandom_range(0, 1) ? SI_STD_TEST : SI_ISUP),
                              2'($urandom_range(0, 3)), $urandom_range(0, 1) ? own_pc() : rand_pc(),
                              rand_pc(), 4'($urandom_range(0, 15)), 8'h11, 8'h20, 2);
                9:
                    build_msu(4'($urandom_range(0, 15)), sh_ni, own_pc(), rand_pc(),
                              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), $urandom_range(0, 4));
                default:
                begin
                    msu.delete();
                    repeat ($urandom_range(1, 12)) msu.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            sent += msu.size();
            send_msu();
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        msg_byte = '0;
        last = 1'b0;
        link_code = '0;
        link_peer_point_code = '0;
        out_stall = 1'b0;
        cycles = 0;
        mismatches = 0;
        stall_hold = 0;
        calm = 1'b0;
        sh_variant = 1'b0;
        sh_own_pc = '0;
        sh_ni = '0;
        sh_link_count = 5'd1;
        clear_message();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration first, then the extremes of both label formats
        test_short_message();
        configure(1'b0, 24'hFFFFFF, 2'd3, 5'd16);
        test_verdicts();
        configure(1'b1, 24'hFFFFFF, 2'd0, 5'd1);
        test_long_message();
        configure(1'b1, 24'h000000, 2'd2, 5'd7);
        test_short_message();

        // random traffic, a link count of zero, one stretch without idling
        configure(1'b0, rand_pc(), 2'd1, 5'd0);
        test_random_traffic(15);
        calm = 1'b1;
        configure(1'b1, rand_pc(), 2'd3, 5'd16);
        test_random_traffic(12);
        calm = 1'b0;

        in_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/md_pkg.sv
rtl/md_ram.sv
rtl/mtp3_message_discriminator_top.sv
tb/mtp3_message_discriminator_top_tb.sv
